/* sv/semiglobal_residue_pair_scorer_unit_macros.svh */
// Assertion macros shared by the semi-global pair scorer modules.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef SEMIGLOBAL_RESIDUE_PAIR_SCORER_UNIT_MACROS_SVH
`define SEMIGLOBAL_RESIDUE_PAIR_SCORER_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define SRPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication outside reset
`define SRPS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/srps_pkg.sv */
// Shared types, constants and scoring functions of the semi-global pair scorer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package srps_pkg;

  localparam int unsigned MaxLetters = 32;
  localparam int unsigned MaxGap     = 8;
  localparam int unsigned LenW       = $clog2(MaxLetters + 1);
  localparam int unsigned IdxW       = $clog2(MaxLetters);
  localparam int unsigned Cols       = MaxLetters + 1;
  localparam int unsigned AddrW      = $clog2(Cols * Cols);
  localparam int unsigned GapW       = $clog2(MaxGap + 1);
  localparam int unsigned HistW      = (MaxGap > 1) ? $clog2(MaxGap) : 1;
  localparam int unsigned ScoreW     = 17;
  localparam int unsigned OutScoreW  = 15;
  localparam int unsigned FlankW     = $clog2(20 * MaxLetters + 21) + 1;
  localparam int unsigned CntW       = $clog2(2 * MaxGap + 2);

  typedef logic signed [ScoreW-1:0] score_t;

  // Configuration register indexes
  localparam logic [1:0] CfgThreshold = 2'd0;
  localparam logic [1:0] CfgGapLimit  = 2'd1;
  localparam logic [1:0] CfgOptLimit  = 2'd2;

  // Edge kinds
  localparam logic [2:0] EdgeSame     = 3'd0;
  localparam logic [2:0] EdgeOptional = 3'd1;
  localparam logic [2:0] EdgeContain  = 3'd2;
  localparam logic [2:0] EdgeInternal = 3'd3;
  localparam logic [2:0] EdgeEmpty    = 3'd5;

  // Trace directions
  localparam logic [1:0] TrMatch  = 2'd0;
  localparam logic [1:0] TrDelete = 2'd1;
  localparam logic [1:0] TrInsert = 2'd2;

  // Class membership per letter, bit c = class c
  localparam logic [12:0] ClassMask [26] = '{
    13'd1696, 13'd0,    13'd2564, 13'd2561, 13'd6145, 13'd5440, 13'd1568,
    13'd2306, 13'd5248, 13'd0,    13'd6146, 13'd5248, 13'd5124, 13'd2568,
    13'd0,    13'd1792, 13'd6152, 13'd6146, 13'd2608, 13'd2576, 13'd0,
    13'd1152, 13'd5440, 13'd0,    13'd6480, 13'd0
  };
  localparam logic signed [7:0] ClassScore [13] = '{
    8'sd80, 8'sd80, 8'sd80, 8'sd80, 8'sd80, 8'sd80, 8'sd60, 8'sd60,
    8'sd55, 8'sd40, 8'sd35, 8'sd35, 8'sd30
  };

  // One pair of stored letters
  typedef struct packed {
    logic            bank;
    logic [LenW-1:0] len_a;
    logic [LenW-1:0] len_b;
    logic            trunc;
    logic [15:0]     pair_idx;
  } job_t;

  // Letter read request from the engine to the letter stores
  typedef struct packed {
    logic            bank;
    logic [IdxW-1:0] addr_a;
    logic [IdxW-1:0] addr_b;
  } let_req_t;

  // Substitution score; first common class wins
  function automatic logic signed [7:0] pair_score(input logic [4:0] a, input logic [4:0] b);
    logic [12:0]      common;
    logic signed [7:0] s;
    common = ClassMask[a] & ClassMask[b];
    s = -8'sd100;
    for (int c = 12; c >= 0; c--) begin
      if (common[c]) s = ClassScore[c];
    end
    if (a == b) s = 8'sd100;
    return s;
  endfunction

  function automatic logic signed [8:0] gap_cost(input logic [GapW-1:0] k);
    logic signed [8:0] g;
    if (k == GapW'(1)) g = -9'sd15;
    else if (k == GapW'(2)) g = -9'sd40;
    else if (k == GapW'(3)) g = -9'sd90;
    else if (k == GapW'(4)) g = -9'sd160;
    else g = -9'sd200;
    return g;
  endfunction

  function automatic logic signed [FlankW-1:0] flank_cost(input logic [LenW-1:0] d);
    logic [FlankW-1:0] p;
    p = FlankW'({d, 4'b0}) + FlankW'({d, 2'b0}) + FlankW'(20);
    return (d == '0) ? '0 : $signed(-p);
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(input logic [LenW-1:0] row,
                                                 input logic [LenW-1:0] col);
    return AddrW'(int'(row) * Cols + int'(col));
  endfunction

endpackage

/* sv/srps_front.sv */
// Front end: takes symbol words, keeps A-Z letters in two banked letter stores.
// Depends on srps_pkg; hands closed pairs to the job queue.
`timescale 1ns / 1ps
module srps_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [7:0] symbol
  input  logic                s_axis_tuser_i,   // [0] word_select
  input  logic                s_axis_tlast_i,   // pair_end
  input  logic                full_i,
  output logic                push_o,
  output srps_pkg::job_t      job_o,
  input  srps_pkg::let_req_t  let_req_i,
  output logic [4:0]          let_a_o,
  output logic [4:0]          let_b_o
);
  import srps_pkg::*;

  logic [4:0]      mem_a [2*MaxLetters];
  logic [4:0]      mem_b [2*MaxLetters];
  logic [LenW-1:0] len_a_q, len_a_d, len_b_q, len_b_d;
  logic            trunc_q, trunc_d, bank_q, bank_d;
  logic [15:0]     pidx_q, pidx_d;
  logic            accept, is_letter, room, wr_a, wr_b;
  logic [LenW-1:0] len_sel, len_a_new, len_b_new;
  logic            trunc_new;
  logic [4:0]      code;

  // Classify the incoming word
  assign s_axis_tready_o = !full_i;
  assign accept    = s_axis_tvalid_i && !full_i;
  assign is_letter = (s_axis_tdata_i >= 8'h41) && (s_axis_tdata_i <= 8'h5A);
  assign len_sel   = s_axis_tuser_i ? len_b_q : len_a_q;
  assign room      = len_sel < LenW'(MaxLetters);
  assign wr_a      = accept && is_letter && room && !s_axis_tuser_i;
  assign wr_b      = accept && is_letter && room && s_axis_tuser_i;
  assign code      = 5'(s_axis_tdata_i - 8'h41);

  assign len_a_new = len_a_q + LenW'(wr_a);
  assign len_b_new = len_b_q + LenW'(wr_b);
  assign trunc_new = trunc_q || (accept && is_letter && !room);

  // Pair close pushes a job and flips the bank
  assign push_o = accept && s_axis_tlast_i;
  assign job_o  = '{bank: bank_q, len_a: len_a_new, len_b: len_b_new,
                    trunc: trunc_new, pair_idx: pidx_q};

  always_comb begin
    len_a_d = len_a_new;
    len_b_d = len_b_new;
    trunc_d = trunc_new;
    bank_d  = bank_q;
    pidx_d  = pidx_q;
    if (push_o) begin
      len_a_d = '0;
      len_b_d = '0;
      trunc_d = 1'b0;
      bank_d  = !bank_q;
      pidx_d  = pidx_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q <= '0;
      len_b_q <= '0;
      trunc_q <= 1'b0;
      bank_q  <= 1'b0;
      pidx_q  <= '0;
    end else begin
      len_a_q <= len_a_d;
      len_b_q <= len_b_d;
      trunc_q <= trunc_d;
      bank_q  <= bank_d;
      pidx_q  <= pidx_d;
    end
  end

  // Letter stores, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wr_a) mem_a[{bank_q, len_a_q[IdxW-1:0]}] <= code;
    if (wr_b) mem_b[{bank_q, len_b_q[IdxW-1:0]}] <= code;
    let_a_o <= mem_a[{let_req_i.bank, let_req_i.addr_a}];
    let_b_o <= mem_b[{let_req_i.bank, let_req_i.addr_b}];
  end

endmodule

/* sv/srps_queue.sv */
// Two-entry job queue between the letter front end and the alignment engine.
// Depends on srps_pkg; the head entry stays until the engine has finished it.
`timescale 1ns / 1ps
module srps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srps_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output srps_pkg::job_t head_o
);
  import srps_pkg::*;
`include "semiglobal_residue_pair_scorer_unit_macros.svh"

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign head_o  = entry_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= job_i;
  end

  `SRPS_ASSERT(a_no_push_full, !(push_i && full_o), "push into full job queue")
  `SRPS_ASSERT(a_no_pop_empty, !(pop_i && empty_o), "pop from empty job queue")

endmodule

/* sv/srps_engine.sv */
// Alignment engine: semi-global DP in both directions, traceback, result output.
// Depends on srps_pkg; holds the configuration registers and the DP matrices.
`timescale 1ns / 1ps
module srps_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [14:0]         cfg_data_i,
  input  logic                empty_i,
  input  srps_pkg::job_t      job_i,
  output logic                pop_o,
  output srps_pkg::let_req_t  let_req_o,
  input  logic [4:0]          let_a_i,
  input  logic [4:0]          let_b_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [39:0]         m_axis_tdata_o  // pair_index, best_score, edge_kind, truncated
);
  import srps_pkg::*;
`include "semiglobal_residue_pair_scorer_unit_macros.svh"

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StStart  = 10'b0000000010,
    StCell   = 10'b0000000100,
    StFetch  = 10'b0000001000,
    StEval   = 10'b0000010000,
    StWrite  = 10'b0000100000,
    StTbStep = 10'b0001000000,
    StTbData = 10'b0010000000,
    StDirEnd = 10'b0100000000,
    StEmit   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic signed [OutScoreW-1:0] thresh_q;
  logic [3:0]                  gap_lim_q;
  logic [5:0]                  opt_lim_q;

  // DP matrices
  score_t     score_mem [Cols*Cols];
  logic [1:0] trace_mem [Cols*Cols];
  score_t     rd_q;
  logic [1:0] tr_q;
  logic                     row0_q;
  logic signed [FlankW-1:0] const_q;

  // Sequencer state
  logic            dir_q, dir_d;
  logic [LenW-1:0] i_q, i_d, j_q, j_d, bend_j_q, bend_j_d;
  logic [CntW-1:0] c_q, c_d;
  score_t          best_q, best_d, bend_q, bend_d, s0_q, s0_d, fin_q, fin_d;
  logic [1:0]      bdir_q, bdir_d;
  logic [2:0]      e0_q, e0_d, fin_e_q, fin_e_d;
  logic [5:0]      run_q, run_d;
  logic            in_run_q, in_run_d, opt_q, opt_d, flank_q, flank_d, int_q, int_d;
  score_t          hist_q [MaxGap];
  logic            shift_hist;

  // Output register
  logic        ovalid_q, ovalid_d;
  logic [39:0] odata_q, odata_d;

  // Derived per-cell values
  logic [LenW-1:0]  m, n, im1, jm1, f_row, f_col, k_del_w;
  logic [GapW-1:0]  gl, k_max, l_max, k_del, k_ins;
  logic [CntW-1:0]  kl_sum, cstart;
  logic             match_ok, is_match, is_del, empty_dir, take, out_free;
  logic [HistW-1:0] hidx;
  score_t           src, cost, v, v_end, sc_dir;
  logic [4:0]       ql, tl;
  logic [2:0]       edge_now;
  logic             run_opt, run_int;
  logic signed [OutScoreW-1:0] clamped;

  assign m  = dir_q ? job_i.len_b : job_i.len_a;
  assign n  = dir_q ? job_i.len_a : job_i.len_b;
  assign im1 = i_q - LenW'(1);
  assign jm1 = j_q - LenW'(1);
  assign empty_dir = (m == '0) || (n == '0);

  // Effective gap limit: zero acts as one, clipped to the longest supported gap
  always_comb begin
    gl = gap_lim_q[GapW-1:0];
    if (gap_lim_q == 4'd0) gl = GapW'(1);
    else if (int'(gap_lim_q) > MaxGap) gl = GapW'(MaxGap);
  end

  // Candidate counts for the current cell
  assign k_max    = (LenW'(gl) < i_q) ? gl : GapW'(i_q);
  assign l_max    = (LenW'(gl) < jm1) ? gl : GapW'(jm1);
  assign kl_sum   = CntW'(k_max) + CntW'(l_max);
  assign match_ok = (j_q >= LenW'(2)) || (i_q == LenW'(1));
  assign cstart   = match_ok ? CntW'(0) : CntW'(1);
  assign is_match = c_q == '0;
  assign is_del   = (c_q != '0) && (c_q <= CntW'(k_max));
  assign k_del    = GapW'(c_q);
  assign k_ins    = GapW'(c_q - CntW'(k_max));
  assign hidx     = HistW'(k_ins - GapW'(1));
  assign k_del_w  = LenW'(k_del);
  assign f_row    = is_match ? im1 : (i_q - k_del_w);
  assign f_col    = is_match ? jm1 : j_q;

  // Letters of the current cell
  assign let_req_o = '{bank: job_i.bank,
                       addr_a: IdxW'(dir_q ? jm1 : im1),
                       addr_b: IdxW'(dir_q ? im1 : jm1)};
  assign ql = dir_q ? let_b_i : let_a_i;
  assign tl = dir_q ? let_a_i : let_b_i;

  // Candidate value
  always_comb begin
    if (is_match || is_del) src = row0_q ? score_t'(const_q) : rd_q;
    else src = hist_q[hidx];
    if (is_match) cost = score_t'(pair_score(ql, tl));
    else cost = score_t'(gap_cost(is_del ? k_del : k_ins));
    v    = src + cost;
    take = (c_q == cstart) || (v > best_q);
  end

  assign v_end   = best_q + score_t'(flank_cost(n - j_q));
  assign run_opt = in_run_q && (run_q <= opt_lim_q);
  assign run_int = in_run_q && (run_q > opt_lim_q);

  always_comb begin
    if (empty_dir) edge_now = EdgeEmpty;
    else if (opt_q) edge_now = EdgeOptional;
    else if (flank_q) edge_now = EdgeContain;
    else if (int_q) edge_now = EdgeInternal;
    else edge_now = EdgeSame;
  end
  assign sc_dir = empty_dir ? '0 : bend_q;

  always_comb begin
    if (fin_q > score_t'(16383)) clamped = 15'sd16383;
    else if (fin_q < -score_t'(16384)) clamped = -15'sd16384;
    else clamped = fin_q[OutScoreW-1:0];
  end
  assign out_free = !ovalid_q || m_axis_tready_i;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    dir_d    = dir_q;
    i_d      = i_q;
    j_d      = j_q;
    c_d      = c_q;
    best_d   = best_q;
    bdir_d   = bdir_q;
    bend_d   = bend_q;
    bend_j_d = bend_j_q;
    s0_d     = s0_q;
    e0_d     = e0_q;
    fin_d    = fin_q;
    fin_e_d  = fin_e_q;
    run_d    = run_q;
    in_run_d = in_run_q;
    opt_d    = opt_q;
    flank_d  = flank_q;
    int_d    = int_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    odata_d  = odata_q;
    pop_o    = 1'b0;
    shift_hist = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          dir_d   = 1'b0;
          state_d = StStart;
        end
      end
      StStart: begin
        i_d      = LenW'(1);
        j_d      = LenW'(1);
        bend_j_d = LenW'(1);
        state_d  = empty_dir ? StDirEnd : StCell;
      end
      StCell: begin
        c_d     = cstart;
        state_d = StFetch;
      end
      StFetch: state_d = StEval;
      StEval: begin
        if (take) begin
          best_d = v;
          bdir_d = is_match ? TrMatch : (is_del ? TrDelete : TrInsert);
        end
        c_d     = c_q + CntW'(1);
        state_d = (c_q == kl_sum) ? StWrite : StFetch;
      end
      StWrite: begin
        shift_hist = 1'b1;
        if ((i_q == m) && ((j_q == LenW'(1)) || (v_end > bend_q))) begin
          bend_d   = v_end;
          bend_j_d = j_q;
        end
        if (j_q < n) begin
          j_d     = j_q + LenW'(1);
          state_d = StCell;
        end else if (i_q < m) begin
          i_d     = i_q + LenW'(1);
          j_d     = LenW'(1);
          state_d = StCell;
        end else begin
          i_d      = m;
          j_d      = bend_j_d;
          run_d    = '0;
          in_run_d = 1'b0;
          opt_d    = 1'b0;
          flank_d  = 1'b0;
          int_d    = 1'b0;
          state_d  = StTbStep;
        end
      end
      StTbStep: begin
        if ((i_q == '0) || (j_q == '0)) begin
          if (i_q == '0 && j_q != '0) flank_d = 1'b1;
          if (run_opt) opt_d = 1'b1;
          if (run_int) int_d = 1'b1;
          in_run_d = 1'b0;
          state_d  = StDirEnd;
        end else begin
          state_d = StTbData;
        end
      end
      StTbData: begin
        if (tr_q == TrDelete) begin
          run_d    = run_q + 6'd1;
          in_run_d = 1'b1;
          i_d      = im1;
        end else begin
          if (run_opt) opt_d = 1'b1;
          if (run_int) int_d = 1'b1;
          run_d    = '0;
          in_run_d = 1'b0;
          j_d      = jm1;
          if (tr_q == TrMatch) i_d = im1;
          else flank_d = 1'b1;
        end
        state_d = StTbStep;
      end
      StDirEnd: begin
        if (!dir_q) begin
          s0_d    = sc_dir;
          e0_d    = edge_now;
          dir_d   = 1'b1;
          state_d = StStart;
        end else begin
          if (s0_q > sc_dir) begin
            fin_d   = s0_q;
            fin_e_d = e0_q;
          end else begin
            fin_d   = sc_dir;
            fin_e_d = edge_now;
          end
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          if (clamped >= thresh_q) begin
            ovalid_d = 1'b1;
            odata_d  = {5'b0, job_i.trunc, fin_e_q, clamped, job_i.pair_idx};
          end
          pop_o   = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ovalid_q  <= 1'b0;
      thresh_q  <= '0;
      gap_lim_q <= 4'd4;
      opt_lim_q <= 6'd4;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgThreshold: thresh_q  <= cfg_data_i;
          CfgGapLimit:  gap_lim_q <= cfg_data_i[3:0];
          CfgOptLimit:  opt_lim_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dir_q    <= dir_d;
    i_q      <= i_d;
    j_q      <= j_d;
    c_q      <= c_d;
    best_q   <= best_d;
    bdir_q   <= bdir_d;
    bend_q   <= bend_d;
    bend_j_q <= bend_j_d;
    s0_q     <= s0_d;
    e0_q     <= e0_d;
    fin_q    <= fin_d;
    fin_e_q  <= fin_e_d;
    run_q    <= run_d;
    in_run_q <= in_run_d;
    opt_q    <= opt_d;
    flank_q  <= flank_d;
    int_q    <= int_d;
    odata_q  <= odata_d;
    if (shift_hist) begin
      hist_q[0] <= best_q;
      for (int h = 1; h < MaxGap; h++) hist_q[h] <= hist_q[h-1];
    end
  end

  // Matrix memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == StWrite) begin
      score_mem[cell_addr(i_q, j_q)] <= best_q;
      trace_mem[cell_addr(i_q, j_q)] <= bdir_q;
    end
    if (state_q == StFetch) begin
      rd_q    <= score_mem[cell_addr(f_row, f_col)];
      row0_q  <= f_row == '0;
      const_q <= flank_cost(f_col);
    end
    if (state_q == StTbStep) tr_q <= trace_mem[cell_addr(i_q, j_q)];
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  `SRPS_ASSERT_IMPL(a_cand_bound, state_q == StEval, c_q <= kl_sum, "candidate index overrun")
  `SRPS_ASSERT_IMPL(a_row_bound, state_q == StWrite, (i_q <= m) && (j_q <= n) && (i_q != '0),
                    "DP cell outside the word lengths")

endmodule

/* sv/semiglobal_residue_pair_scorer_unit.sv */
// Each direction of a pair steps every one of its m*n cells through the candidates
// (match plus up to gap_limit deletes and inserts) one at a time, then runs a traceback;
// one score memory read port sets the pace. Letters are taken one per cycle while the job
// queue is not full; the next pair loads while the engine works. Reset clears control,
// front and queue counters and configuration; letter and DP stores are not cleared.
`timescale 1ns / 1ps
module semiglobal_residue_pair_scorer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tuser_i,   // [0] word_select
  input  logic        s_axis_tlast_i,   // pair_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [15:0] pair_index, [30:16] best_score,
                                        // [33:31] edge_kind, [34] truncated
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);
  import srps_pkg::*;

  job_t     push_job, head_job;
  let_req_t let_req;
  logic     push, pop, full, empty;
  logic [4:0] let_a, let_b;

  // Letter intake
  srps_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i, .s_axis_tlast_i,
    .full_i(full), .push_o(push), .job_o(push_job),
    .let_req_i(let_req), .let_a_o(let_a), .let_b_o(let_b)
  );

  // Pair queue
  srps_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .job_i(push_job), .pop_i(pop),
    .full_o(full), .empty_o(empty), .head_o(head_job)
  );

  // Alignment and result
  srps_engine u_engine (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .empty_i(empty), .job_i(head_job), .pop_o(pop),
    .let_req_o(let_req), .let_a_i(let_a), .let_b_i(let_b),
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

endmodule
